>>> hw/rtl/detector_hit_merge_table_core_macros.svh
// Assertion macros shared by the hit merge table checker.
`ifndef DETECTOR_HIT_MERGE_TABLE_CORE_MACROS_SVH
`define DETECTOR_HIT_MERGE_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DHMT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hit merge table check failed");

// Next-cycle implication, checked outside reset.
`define DHMT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hit merge table check failed");

// Implication that is also checked during reset.
`define DHMT_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |-> (cons)) \
        else $error("hit merge table check failed");

`endif

>>> hw/rtl/dhmt_pkg.sv
// Types and constants of the detector hit merge table.
package dhmt_pkg;

    localparam logic [1:0] CMD_STEP  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] REG_TIME_FACTOR = 2'd0;
    localparam logic [1:0] REG_STORE_CUT   = 2'd1;
    localparam logic [1:0] REG_HISTORY_CUT = 2'd2;

    localparam logic [24:0] NO_TRACK = 25'h1FFFFFF;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [23:0] energy_deposit;
        logic        is_em;
        logic        is_neutral;
        logic [31:0] entry_time;
        logic [31:0] exit_time;
        logic [31:0] unit_id;
        logic [23:0] track_id;
        logic [31:0] incident_energy;
        logic [7:0]  read_index;
    } t_item;

    typedef struct packed {
        logic [7:0]  hit_index;
        logic        created;
        logic        table_full;
        logic        store_track;
        logic        keep_history;
        logic        entry_valid;
        logic [31:0] entry_unit;
        logic [15:0] entry_slice;
        logic [31:0] entry_energy_em;
        logic [31:0] entry_energy_had;
        logic [31:0] entry_tof;
        logic [23:0] entry_track;
    } t_result;

    // One table entry as stored in memory.
    typedef struct packed {
        logic [31:0] unit;
        logic [15:0] slice;
        logic [31:0] energy_em;
        logic [31:0] energy_had;
        logic [31:0] tof;
        logic [23:0] track;
    } t_hit;

endpackage

>>> hw/rtl/detector_hit_merge_table_core.sv
// Top level of the detector hit merge table: sequencer around one entry memory.
// Reads, clears and ignored steps finish after decode; a step ends in a last-hit
// match, a new entry, or a table search over the stored entries.
// Throughput: one item at a time; a search reads one memory entry per cycle.
// The result strobe o_valid is high one cycle; busy stays high until then.
// Reset (synchronous, active low) empties the table and restores the registers.
module detector_hit_merge_table_core #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  dhmt_pkg::t_item   i_item,
    output logic              o_valid,
    output dhmt_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data
);
    import dhmt_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = (CW > 8) ? CW : 8;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_RD, S_KEY, S_LOOK, S_SCAN, S_UPD, S_NEW
    } t_state;

    t_state        r_state, n_state;
    t_item         r_item, n_item;
    logic [47:0]   r_prod, n_prod;
    logic [15:0]   r_slice, n_slice;
    logic          r_store, n_store, r_hist, n_hist;
    logic [CW-1:0] r_count, n_count, r_scan, n_scan;
    logic          r_lvalid, n_lvalid;
    logic [IW-1:0] r_lidx, n_lidx, r_prev, n_prev, r_idx, n_idx;
    logic [15:0]   r_lslice, n_lslice;
    logic [31:0]   r_lunit, n_lunit;
    logic [24:0]   r_ltrack, n_ltrack;
    logic [15:0]   r_tf, n_tf;
    logic [31:0]   r_scut, n_scut, r_hcut, n_hcut;
    logic          r_pend, n_pend, r_from_scan, n_from_scan;
    t_result       r_res, n_res;
    logic          r_valid, n_valid;

    // Entry memory with registered read data.
    t_hit          mem [TABLE_DEPTH];
    t_hit          r_rdata, wdata, upd;
    logic          mem_re, mem_we;
    logic [IW-1:0] raddr, waddr;
    logic [31:0]   tof, dep;
    logic [32:0]   sum;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[raddr];
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;
    assign tof      = r_item.is_neutral ? r_item.exit_time : r_item.entry_time;
    assign dep      = {8'd0, r_item.energy_deposit};

    // Sequencer and register updates.
    always_comb begin
        n_state = r_state;   n_item = r_item;     n_prod = r_prod;
        n_slice = r_slice;   n_store = r_store;   n_hist = r_hist;
        n_count = r_count;   n_scan = r_scan;     n_lvalid = r_lvalid;
        n_lidx = r_lidx;     n_prev = r_prev;     n_idx = r_idx;
        n_lslice = r_lslice; n_lunit = r_lunit;   n_ltrack = r_ltrack;
        n_tf = r_tf;         n_scut = r_scut;     n_hcut = r_hcut;
        n_pend = r_pend;     n_from_scan = r_from_scan;
        n_res = r_res;       n_valid = 1'b0;
        mem_re = 1'b0;       mem_we = 1'b0;
        raddr = r_scan[IW-1:0];
        waddr = r_idx;
        wdata = r_rdata;
        upd = r_rdata;
        sum = '0;

        // Register writes; a zero write leaves the register unchanged.
        if (i_cfg_we && (i_cfg_data != 32'd0)) begin
            unique case (i_cfg_idx)
                REG_TIME_FACTOR: begin
                    if (i_cfg_data[15:0] != 16'd0) begin
                        n_tf = i_cfg_data[15:0];
                    end
                end
                REG_STORE_CUT:   n_scut = i_cfg_data;
                REG_HISTORY_CUT: n_hcut = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_prod = 48'(r_tf) * 48'(r_item.entry_time);
                n_res = '0;
                if (r_item.cmd == CMD_READ) begin
                    mem_re = 1'b1;
                    raddr = IW'(r_item.read_index);
                    n_state = S_RD;
                end else if (r_item.cmd == CMD_CLEAR) begin
                    n_count = '0;
                    n_lvalid = 1'b0;
                    n_ltrack = NO_TRACK;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (r_item.cmd == CMD_STEP && r_item.energy_deposit != 24'd0) begin
                    n_state = S_KEY;
                end else begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                n_res.hit_index = r_item.read_index;
                if (RW'(r_item.read_index) < RW'(r_count)) begin
                    n_res.entry_valid = 1'b1;
                    n_res.entry_unit = r_rdata.unit;
                    n_res.entry_slice = r_rdata.slice;
                    n_res.entry_energy_em = r_rdata.energy_em;
                    n_res.entry_energy_had = r_rdata.energy_had;
                    n_res.entry_tof = r_rdata.tof;
                    n_res.entry_track = r_rdata.track;
                end
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_KEY: begin
                n_slice = (r_prod[47:32] != 16'd0) ? 16'hFFFF : r_prod[31:16];
                n_store = 1'b0;
                n_hist = 1'b0;
                if ({1'b0, r_item.track_id} != r_ltrack) begin
                    n_ltrack = {1'b0, r_item.track_id};
                    n_store = (r_item.incident_energy > r_scut);
                    n_hist = (r_item.incident_energy > r_hcut);
                end
                n_state = S_LOOK;
            end
            S_LOOK: begin
                if (r_lvalid && r_slice == r_lslice && r_item.unit_id == r_lunit) begin
                    mem_re = 1'b1;
                    raddr = r_lidx;
                    n_idx = r_lidx;
                    n_from_scan = 1'b0;
                    n_state = S_UPD;
                end else if (r_lvalid) begin
                    n_scan = '0;
                    n_pend = 1'b0;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_NEW;
                end
            end
            S_SCAN: begin
                // Compare the entry read last cycle while reading the next one.
                if (r_pend && r_rdata.slice == r_slice && r_rdata.unit == r_item.unit_id) begin
                    n_idx = r_prev;
                    n_from_scan = 1'b1;
                    n_state = S_UPD;
                end else if (r_scan < r_count) begin
                    mem_re = 1'b1;
                    raddr = r_scan[IW-1:0];
                    n_prev = r_scan[IW-1:0];
                    n_scan = r_scan + CW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_state = S_NEW;
                end
            end
            S_UPD: begin
                if (r_from_scan && tof < r_rdata.tof) begin
                    upd.tof = tof;
                    upd.track = r_item.track_id;
                end
                if (r_item.is_em) begin
                    sum = {1'b0, r_rdata.energy_em} + {1'b0, dep};
                    upd.energy_em = sum[32] ? 32'hFFFFFFFF : sum[31:0];
                end else begin
                    sum = {1'b0, r_rdata.energy_had} + {1'b0, dep};
                    upd.energy_had = sum[32] ? 32'hFFFFFFFF : sum[31:0];
                end
                wdata = upd;
                mem_we = 1'b1;
                waddr = r_idx;
                n_lvalid = 1'b1;
                n_lidx = r_idx;
                n_lslice = r_slice;
                n_lunit = r_item.unit_id;
                n_res.hit_index = 8'(r_idx);
                n_res.store_track = r_store;
                n_res.keep_history = r_hist;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_NEW: begin
                n_res.store_track = r_store;
                n_res.keep_history = r_hist;
                if (r_count >= CW'(TABLE_DEPTH)) begin
                    n_res.table_full = 1'b1;
                end else begin
                    wdata.unit = r_item.unit_id;
                    wdata.slice = r_slice;
                    wdata.energy_em = r_item.is_em ? dep : 32'd0;
                    wdata.energy_had = r_item.is_em ? 32'd0 : dep;
                    wdata.tof = tof;
                    wdata.track = r_item.track_id;
                    mem_we = 1'b1;
                    waddr = r_count[IW-1:0];
                    n_count = r_count + CW'(1);
                    n_lvalid = 1'b1;
                    n_lidx = r_count[IW-1:0];
                    n_lslice = r_slice;
                    n_lunit = r_item.unit_id;
                    n_res.hit_index = 8'(r_count[IW-1:0]);
                    n_res.created = 1'b1;
                end
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, control and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_lvalid <= 1'b0;
            r_lidx <= '0;
            r_lslice <= '0;
            r_lunit <= '0;
            r_ltrack <= NO_TRACK;
            r_tf <= 16'd256;
            r_scut <= 32'hFFFFFFFF;
            r_hcut <= 32'hFFFFFFFF;
            r_valid <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_lvalid <= n_lvalid;
            r_lidx <= n_lidx;
            r_lslice <= n_lslice;
            r_lunit <= n_lunit;
            r_ltrack <= n_ltrack;
            r_tf <= n_tf;
            r_scut <= n_scut;
            r_hcut <= n_hcut;
            r_valid <= n_valid;
            r_pend <= n_pend;
        end
        r_item <= n_item;
        r_prod <= n_prod;
        r_slice <= n_slice;
        r_store <= n_store;
        r_hist <= n_hist;
        r_scan <= n_scan;
        r_prev <= n_prev;
        r_idx <= n_idx;
        r_from_scan <= n_from_scan;
        r_res <= n_res;
    end

endmodule

>>> hw/rtl/dhmt_chk.sv
// Port checker for the hit merge table and its bind to the top level.
`include "detector_hit_merge_table_core_macros.svh"

module dhmt_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input dhmt_pkg::t_result o_result
);
    import dhmt_pkg::*;

    // A result only appears once the block has gone idle.
    `DHMT_ASSERT_NOW(a_valid_idle, o_valid, !busy)
    // Every accepted item keeps the block busy in the next cycle.
    `DHMT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // A dropped hit never reports a new entry, and a read never creates one.
    `DHMT_ASSERT_NOW(a_full_created, o_valid && (o_result.table_full || o_result.entry_valid),
        !o_result.created)
    // No result follows a reset cycle.
    `DHMT_ASSERT_ALWAYS(a_reset_quiet, $past(!i_rst_n), !o_valid)

endmodule

bind detector_hit_merge_table_core dhmt_chk u_dhmt_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

>>> verif/tb_detector_hit_merge_table_core.sv
// Self-checking testbench for the detector hit merge table core.
`timescale 1ns / 1ps

module tb_detector_hit_merge_table_core;
    import dhmt_pkg::*;

    localparam int DEPTH = 256;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        o_valid;
    t_result     o_result;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    detector_hit_merge_table_core #(.TABLE_DEPTH(DEPTH)) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (i_item),
        .o_valid   (o_valid),
        .o_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // Clock with a 4 ns period.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Mirror of the hit table, the last-hit cache and the registers.
    logic [31:0] tbl_unit [DEPTH];
    logic [15:0] tbl_slice [DEPTH];
    logic [31:0] tbl_em [DEPTH];
    logic [31:0] tbl_had [DEPTH];
    logic [31:0] tbl_tof [DEPTH];
    logic [23:0] tbl_track [DEPTH];
    int unsigned tbl_count;
    logic        cache_valid;
    logic [7:0]  cache_index;
    logic [15:0] cache_slice;
    logic [31:0] cache_unit;
    logic [24:0] prev_track;
    logic [15:0] time_factor;
    logic [31:0] store_cut;
    logic [31:0] history_cut;

    t_result expected_hits[$];
    int      fail_count = 0;
    bit      allow_idle = 1'b1;

    function automatic logic [31:0] add_saturated(logic [31:0] a, logic [23:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {9'd0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // Apply a register write to the mirror; writes of zero are dropped.
    function automatic void mirror_reg_write(logic [1:0] idx, logic [31:0] data);
        if (idx == REG_TIME_FACTOR) begin
            if (data[15:0] != 16'd0) time_factor = data[15:0];
        end else if (idx == REG_STORE_CUT) begin
            if (data != 32'd0) store_cut = data;
        end else if (idx == REG_HISTORY_CUT) begin
            if (data != 32'd0) history_cut = data;
        end
    endfunction

    // Work out the result of one item and update the mirrored table.
    function automatic t_result merge_hit(t_item it);
        t_result     r;
        logic [31:0] tof;
        logic [63:0] prod;
        logic [15:0] slice;
        int unsigned idx;
        bit          found;
        r = '0;
        if (it.cmd == CMD_READ) begin
            r.hit_index = it.read_index;
            if (it.read_index < tbl_count) begin
                r.entry_valid      = 1'b1;
                r.entry_unit       = tbl_unit[it.read_index];
                r.entry_slice      = tbl_slice[it.read_index];
                r.entry_energy_em  = tbl_em[it.read_index];
                r.entry_energy_had = tbl_had[it.read_index];
                r.entry_tof        = tbl_tof[it.read_index];
                r.entry_track      = tbl_track[it.read_index];
            end
            return r;
        end
        if (it.cmd == CMD_CLEAR) begin
            tbl_count   = 0;
            cache_valid = 1'b0;
            prev_track  = NO_TRACK;
            return r;
        end
        if (it.cmd != CMD_STEP || it.energy_deposit == 24'd0) return r;

        tof   = it.is_neutral ? it.exit_time : it.entry_time;
        prod  = ({48'd0, time_factor} * {32'd0, it.entry_time}) >> 16;
        slice = (prod > 64'hFFFF) ? 16'hFFFF : prod[15:0];
        idx   = 0;
        found = 1'b0;

        // Track flags are raised only when the track id changes.
        if ({1'b0, it.track_id} != prev_track) begin
            prev_track     = {1'b0, it.track_id};
            r.store_track  = it.incident_energy > store_cut;
            r.keep_history = it.incident_energy > history_cut;
        end

        if (cache_valid && slice == cache_slice && it.unit_id == cache_unit) begin
            idx   = {24'd0, cache_index};
            found = 1'b1;
        end else if (cache_valid) begin
            for (int j = 0; j < tbl_count; j++) begin
                if (tbl_slice[j] == slice && tbl_unit[j] == it.unit_id) begin
                    idx   = j;
                    found = 1'b1;
                    if (tof < tbl_tof[j]) begin
                        tbl_tof[j]   = tof;
                        tbl_track[j] = it.track_id;
                    end
                    break;
                end
            end
        end

        if (!found) begin
            if (tbl_count >= DEPTH) begin
                r.table_full = 1'b1;
                return r;
            end
            idx            = tbl_count;
            tbl_unit[idx]  = it.unit_id;
            tbl_slice[idx] = slice;
            tbl_em[idx]    = '0;
            tbl_had[idx]   = '0;
            tbl_tof[idx]   = tof;
            tbl_track[idx] = it.track_id;
            tbl_count++;
            r.created = 1'b1;
        end

        if (it.is_em) tbl_em[idx] = add_saturated(tbl_em[idx], it.energy_deposit);
        else tbl_had[idx] = add_saturated(tbl_had[idx], it.energy_deposit);
        cache_valid = 1'b1;
        cache_index = idx[7:0];
        cache_slice = slice;
        cache_unit  = it.unit_id;
        r.hit_index = idx[7:0];
        return r;
    endfunction

    // Send one item; called at a falling edge and returns at a falling edge.
    task automatic send_item(t_item it);
        i_item = it;
        start  = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_hits.push_back(merge_hit(it));
        @(negedge i_clk);
        start = 1'b0;
        if (allow_idle && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 13)) @(negedge i_clk);
    endtask

    // Wait until every expected result has come and the block has settled.
    task automatic wait_drained();
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        mirror_reg_write(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_item step_item(logic [31:0] unit, logic [31:0] t_in,
                                        logic [23:0] dep, logic [23:0] track);
        t_item it;
        it = '0;
        it.cmd             = CMD_STEP;
        it.unit_id         = unit;
        it.entry_time      = t_in;
        it.exit_time       = t_in + 32'd100;
        it.energy_deposit  = dep;
        it.track_id        = track;
        it.incident_energy = 32'd1000;
        return it;
    endfunction

    function automatic t_item cmd_item(logic [1:0] cmd, logic [7:0] ridx);
        t_item it;
        it = '0;
        it.cmd        = cmd;
        it.read_index = ridx;
        return it;
    endfunction

    // Random item: mostly steps on a few units and slices so that hits merge.
    function automatic t_item random_item();
        t_item        it;
        logic [223:0] raw;
        int unsigned  pick;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(t_item)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 8) it.cmd = CMD_READ;
        else if (pick < 10) it.cmd = CMD_CLEAR;
        else if (pick < 12) it.cmd = CMD_NOP;
        else it.cmd = CMD_STEP;
        if ($urandom_range(0, 3) != 0) it.unit_id = $urandom_range(0, 5);
        if ($urandom_range(0, 3) != 0) it.entry_time = $urandom_range(0, 2047);
        if ($urandom_range(0, 2) != 0) it.exit_time = it.entry_time + $urandom_range(0, 500);
        if ($urandom_range(0, 2) != 0) it.track_id = 24'($urandom_range(0, 3));
        pick = $urandom_range(0, 19);
        if (pick == 0) it.energy_deposit = '0;
        else if (pick == 1) it.energy_deposit = 24'hFF_FFFF;
        else if (pick < 14) it.energy_deposit = 24'($urandom_range(1, 5000));
        if (it.cmd == CMD_READ && $urandom_range(0, 1)) it.read_index = 8'($urandom_range(0, 15));
        return it;
    endfunction

    // Compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid) begin
            if (expected_hits.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_result);
                fail_count++;
            end else begin
                e = expected_hits.pop_front();
                if (e.hit_index !== o_result.hit_index)
                    $display("%0t: hit_index exp %h got %h", $time, e.hit_index,
                             o_result.hit_index);
                if (e.created !== o_result.created)
                    $display("%0t: created exp %h got %h", $time, e.created, o_result.created);
                if (e.table_full !== o_result.table_full)
                    $display("%0t: table_full exp %h got %h", $time, e.table_full,
                             o_result.table_full);
                if (e.store_track !== o_result.store_track)
                    $display("%0t: store_track exp %h got %h", $time, e.store_track,
                             o_result.store_track);
                if (e.keep_history !== o_result.keep_history)
                    $display("%0t: keep_history exp %h got %h", $time, e.keep_history,
                             o_result.keep_history);
                if (e.entry_valid !== o_result.entry_valid)
                    $display("%0t: entry_valid exp %h got %h", $time, e.entry_valid,
                             o_result.entry_valid);
                if (e.entry_unit !== o_result.entry_unit)
                    $display("%0t: entry_unit exp %h got %h", $time, e.entry_unit,
                             o_result.entry_unit);
                if (e.entry_slice !== o_result.entry_slice)
                    $display("%0t: entry_slice exp %h got %h", $time, e.entry_slice,
                             o_result.entry_slice);
                if (e.entry_energy_em !== o_result.entry_energy_em)
                    $display("%0t: entry_energy_em exp %h got %h", $time, e.entry_energy_em,
                             o_result.entry_energy_em);
                if (e.entry_energy_had !== o_result.entry_energy_had)
                    $display("%0t: entry_energy_had exp %h got %h", $time,
                             e.entry_energy_had, o_result.entry_energy_had);
                if (e.entry_tof !== o_result.entry_tof)
                    $display("%0t: entry_tof exp %h got %h", $time, e.entry_tof,
                             o_result.entry_tof);
                if (e.entry_track !== o_result.entry_track)
                    $display("%0t: entry_track exp %h got %h", $time, e.entry_track,
                             o_result.entry_track);
                if (e !== o_result) fail_count++;
            end
        end
    end

    // Steps, merges, reads, clears, ignored items and the track flags.
    task automatic test_directed();
        t_item it;
        send_item(step_item(32'd7, 32'd0, 24'd10, 24'd1));
        send_item(step_item(32'd7, 32'd10, 24'd20, 24'd1));
        send_item(step_item(32'd8, 32'd300, 24'd5, 24'd2));
        it = step_item(32'd7, 32'd20, 24'd30, 24'd3);
        it.is_em = 1'b1;
        send_item(it);
        it = step_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        it.is_neutral      = 1'b1;
        it.exit_time       = 32'hFFFF_FFFF;
        it.incident_energy = 32'hFFFF_FFFF;
        send_item(it);
        send_item(step_item(32'd8, 32'd256, 24'd0, 24'd4));
        it = step_item(32'd7, 32'd5, 24'd1, 24'd5);
        it.entry_time = 32'd0;
        send_item(it);
        send_item(step_item(32'd8, 32'd300, 24'd1, 24'd6));
        it = cmd_item(CMD_NOP, 8'd0);
        it.energy_deposit = 24'd9;
        send_item(it);
        for (int k = 0; k < 5; k++) send_item(cmd_item(CMD_READ, k[7:0]));
        send_item(cmd_item(CMD_READ, 8'hFF));
        send_item(cmd_item(CMD_CLEAR, 8'd0));
        send_item(cmd_item(CMD_READ, 8'd0));
        send_item(step_item(32'd7, 32'd0, 24'd1, 24'd1));
    endtask

    // Full-scale deposits drive the electromagnetic sum into saturation;
    // a few hadronic deposits then land on the same entry.
    task automatic test_saturation();
        t_item it;
        send_item(cmd_item(CMD_CLEAR, 8'd0));
        for (int k = 0; k < 260; k++) begin
            it = step_item(32'd42, 32'd512, 24'hFF_FFFF, 24'd9);
            it.is_em = (k < 258);
            send_item(it);
        end
        send_item(cmd_item(CMD_READ, 8'd0));
    endtask

    // Fill the table to its depth and then offer one more new hit.
    task automatic test_table_full();
        send_item(cmd_item(CMD_CLEAR, 8'd0));
        for (int k = 0; k <= DEPTH; k++) send_item(step_item(k, 32'd0, 24'd3, 24'd1));
        send_item(step_item(32'd5, 32'd0, 24'd3, 24'd1));
        send_item(cmd_item(CMD_READ, 8'd255));
        send_item(cmd_item(CMD_CLEAR, 8'd0));
    endtask

    // Random phases under changing register settings; a zero write keeps the old value.
    task automatic test_random();
        logic [31:0] tf_set [4]    = '{32'd1, 32'hFFFF, 32'd256, 32'h1_0080};
        logic [31:0] store_set [4] = '{32'd1, 32'd2000, 32'hFFFF_FFFF, 32'd0};
        logic [31:0] hist_set [4]  = '{32'hFFFF_FFFF, 32'd1, 32'd0, 32'd500};
        for (int p = 0; p < 4; p++) begin
            wait_drained();
            write_reg(REG_TIME_FACTOR, tf_set[p]);
            write_reg(REG_STORE_CUT, store_set[p]);
            write_reg(REG_HISTORY_CUT, hist_set[p]);
            write_reg(REG_TIME_FACTOR, 32'd0);
            if (p == 3) allow_idle = 1'b0;
            for (int k = 0; k < 25; k++) send_item(random_item());
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_TIME_FACTOR;
        i_cfg_data  = '0;
        tbl_count   = 0;
        cache_valid = 1'b0;
        cache_index = '0;
        cache_slice = '0;
        cache_unit  = '0;
        prev_track  = NO_TRACK;
        time_factor = 16'd256;
        store_cut   = 32'hFFFF_FFFF;
        history_cut = 32'hFFFF_FFFF;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        wait_drained();
        write_reg(REG_STORE_CUT, 32'd999);
        write_reg(REG_HISTORY_CUT, 32'd1000);
        test_directed();
        test_saturation();
        test_table_full();
        test_random();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** detector_hit_merge_table_core: PASSED **");
        end else begin
            $display("** detector_hit_merge_table_core: FAILED **");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #20ms;
        $display("** detector_hit_merge_table_core: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/dhmt_pkg.sv
hw/rtl/detector_hit_merge_table_core.sv
hw/rtl/dhmt_chk.sv
verif/tb_detector_hit_merge_table_core.sv
